/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the slot cache.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the synchronous active-low reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the synchronous active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/plsc_pkg.sv */
// Package for the pinned LRU slot cache: codes, widths and the scan/command structs.
// No dependencies.
package plsc_pkg;

    localparam int SLOTS_DEF    = 32;
    localparam int REF_BITS_DEF = 8;
    localparam int IDX_W        = 8;   // holds any slot index up to 256 slots
    localparam int ADDR_W       = 32;
    localparam int NUM_W        = 16;
    localparam int CLK_W        = 32;
    localparam int REL_W        = 5;
    localparam int OSLOT_W      = 5;
    localparam int STS_W        = 2;

    localparam logic FUNC_LOOKUP  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STS_W-1:0] STS_HIT   = 2'd0;
    localparam logic [STS_W-1:0] STS_FILL  = 2'd1;
    localparam logic [STS_W-1:0] STS_EVICT = 2'd2;
    localparam logic [STS_W-1:0] STS_NONE  = 2'd3;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_PIN  = 2'd1;
    localparam logic [1:0] CMD_FILL = 2'd2;
    localparam logic [1:0] CMD_DROP = 2'd3;

    // Search record that walks down the chain of cells.
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_any;
        logic [IDX_W-1:0] free_idx;
        logic             vic_any;
        logic [IDX_W-1:0] vic_idx;
        logic [CLK_W-1:0] vic_age;
    } t_pkt;

    // Update broadcast to every cell; only the addressed one acts.
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

endpackage

/* src/plsc_cell.sv */
// One slot of the cache: tag, pin count, use stamp, and one stage of the search chain.
// Depends on plsc_pkg.
module plsc_cell import plsc_pkg::*; #(
    parameter int SLOT_IDX = 0,
    parameter int REF_BITS = REF_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pkt              i_pkt,
    output t_pkt              o_pkt,
    input  t_cmd              i_cmd,
    input  logic [ADDR_W-1:0] i_key_addr,
    input  logic [NUM_W-1:0]  i_key_num,
    input  logic [CLK_W-1:0]  i_clock
);

    localparam logic [IDX_W-1:0]    ME      = IDX_W'(SLOT_IDX);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    logic                r_valid;
    logic [ADDR_W-1:0]   r_tag_addr;
    logic [NUM_W-1:0]    r_tag_num;
    logic [REF_BITS-1:0] r_ref;
    logic [REF_BITS-1:0] n_ref;
    logic [CLK_W-1:0]    r_last_use;
    t_pkt                r_pkt;
    t_pkt                n_pkt;
    logic [CLK_W-1:0]    age;
    logic                hit_here;
    logic                sel;

    assign age      = i_clock - r_last_use;
    assign hit_here = r_valid && (r_tag_addr == i_key_addr) && (r_tag_num == i_key_num);
    assign sel      = (i_cmd.op != CMD_NONE) && (i_cmd.idx == ME);

    // Fold this slot into the search record: first hit, last free, oldest unpinned.
    always_comb begin
        n_pkt = i_pkt;
        if (!i_pkt.hit && hit_here) begin
            n_pkt.hit     = 1'b1;
            n_pkt.hit_idx = ME;
        end
        if (!r_valid) begin
            n_pkt.free_any = 1'b1;
            n_pkt.free_idx = ME;
        end
        if ((r_ref == '0) && (!i_pkt.vic_any || (age > i_pkt.vic_age))) begin
            n_pkt.vic_any = 1'b1;
            n_pkt.vic_idx = ME;
            n_pkt.vic_age = age;
        end
    end

    always_comb begin
        n_ref = r_ref;
        unique case (i_cmd.op)
            CMD_PIN:  if (r_ref != REF_MAX) n_ref = r_ref + REF_BITS'(1);
            CMD_FILL: n_ref = REF_BITS'(1);
            CMD_DROP: if (r_ref != '0) n_ref = r_ref - REF_BITS'(1);
            default:  n_ref = r_ref;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_ref      <= '0;
            r_last_use <= '0;
            r_pkt.vld  <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
            if (sel) begin
                r_ref <= n_ref;
                if (i_cmd.op == CMD_FILL) r_valid <= 1'b1;
                if (i_cmd.op == CMD_PIN || i_cmd.op == CMD_FILL) r_last_use <= i_clock;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.op == CMD_FILL) begin
            r_tag_addr <= i_key_addr;
            r_tag_num  <= i_key_num;
        end
    end

    assign o_pkt = r_pkt;

endmodule

/* src/pinned_lru_slot_cache.sv */
// Top level of the pinned LRU slot cache: handshakes, sequencer and the chain of slot cells.
// Depends on plsc_pkg, plsc_cell and assert_macros.svh.
//
//   channel | handshake            | fields
//   --------+----------------------+-----------------------------------------------
//   request | i_valid / o_stall    | i_func, i_key_addr, i_key_num, i_release_slot
//   result  | o_valid / i_stall    | o_slot, o_status
//
// A lookup sends one search record down the chain of SLOTS cells, one cell per cycle;
// the record is then captured and committed, and o_valid is registered at the commit.
// The request side stays stalled until the sequencer returns to idle after the commit.
// A release skips the chain and goes straight from accept to the commit state.
// Reset is synchronous, active low, and clears every valid bit, pin count and stamp
// at once; tags stay unwritten until a fill.
// A result held under i_stall holds the commit; the request side waits with o_stall.
module pinned_lru_slot_cache import plsc_pkg::*; #(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int REF_BITS = REF_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic [ADDR_W-1:0]  i_key_addr,
    input  logic [NUM_W-1:0]   i_key_num,
    input  logic [REL_W-1:0]   i_release_slot,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [OSLOT_W-1:0] o_slot,
    output logic [STS_W-1:0]   o_status
);

    `include "assert_macros.svh"

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic               r_launch;
    logic               r_func;
    logic [ADDR_W-1:0]  r_key_addr;
    logic [NUM_W-1:0]   r_key_num;
    logic [REL_W-1:0]   r_rel;
    logic [CLK_W-1:0]   r_clock;
    t_pkt               r_res;
    logic               r_out_valid;
    logic [OSLOT_W-1:0] r_out_slot;
    logic [STS_W-1:0]   r_out_sts;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               rel_ok;
    t_cmd               n_cmd;
    t_cmd               w_cmd;
    logic [IDX_W-1:0]   n_idx;
    logic [STS_W-1:0]   n_sts;
    logic               n_tick;
    t_pkt               w_launch;
    t_pkt               w_chain [SLOTS];

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign commit   = (r_state == ST_FIN) && out_free;
    assign rel_ok   = (9'(r_rel) < 9'(SLOTS));

    // Fresh search record enters the first cell the cycle after accept.
    always_comb begin
        w_launch     = '0;
        w_launch.vld = r_launch;
    end

    // Chain of slot cells; each stage hands the record on every cycle.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            plsc_cell #(.SLOT_IDX(g), .REF_BITS(REF_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_pkt      (w_launch),
                .o_pkt      (w_chain[g]),
                .i_cmd      (w_cmd),
                .i_key_addr (r_key_addr),
                .i_key_num  (r_key_num),
                .i_clock    (r_clock)
            );
        end else begin : g_body
            plsc_cell #(.SLOT_IDX(g), .REF_BITS(REF_BITS)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_pkt      (w_chain[g-1]),
                .o_pkt      (w_chain[g]),
                .i_cmd      (w_cmd),
                .i_key_addr (r_key_addr),
                .i_key_num  (r_key_num),
                .i_clock    (r_clock)
            );
        end
    end

    // Decide the outcome from the captured search record, or from the release slot.
    // Priority: hit, then highest free slot, then oldest unpinned slot, else nothing.
    always_comb begin
        n_cmd.op  = CMD_NONE;
        n_cmd.idx = '0;
        n_idx     = '0;
        n_sts     = STS_NONE;
        n_tick    = 1'b0;
        priority if (r_func == FUNC_RELEASE) begin
            n_idx = IDX_W'(r_rel);
            if (rel_ok) begin
                n_cmd.op  = CMD_DROP;
                n_cmd.idx = IDX_W'(r_rel);
                n_sts     = STS_HIT;
            end
        end else if (r_res.hit) begin
            n_cmd.op  = CMD_PIN;
            n_cmd.idx = r_res.hit_idx;
            n_idx     = r_res.hit_idx;
            n_sts     = STS_HIT;
            n_tick    = 1'b1;
        end else if (r_res.free_any) begin
            n_cmd.op  = CMD_FILL;
            n_cmd.idx = r_res.free_idx;
            n_idx     = r_res.free_idx;
            n_sts     = STS_FILL;
            n_tick    = 1'b1;
        end else if (r_res.vic_any) begin
            n_cmd.op  = CMD_FILL;
            n_cmd.idx = r_res.vic_idx;
            n_idx     = r_res.vic_idx;
            n_sts     = STS_EVICT;
            n_tick    = 1'b1;
        end else begin
            // Every slot pinned: report slot 0, touch nothing, hold the counter.
            n_idx = '0;
            n_sts = STS_NONE;
        end
    end

    // Broadcast the update only in the commit cycle.
    always_comb begin
        w_cmd = n_cmd;
        if (!commit) w_cmd.op = CMD_NONE;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = (i_func == FUNC_RELEASE) ? ST_FIN : ST_SCAN;
            ST_SCAN: if (w_chain[SLOTS-1].vld) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept && (i_func == FUNC_LOOKUP);
            if (commit && n_tick) r_clock <= r_clock + CLK_W'(1);
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: request latch, captured search record, result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func     <= i_func;
            r_key_addr <= i_key_addr;
            r_key_num  <= i_key_num;
            r_rel      <= i_release_slot;
        end
        if (r_state == ST_SCAN && w_chain[SLOTS-1].vld) r_res <= w_chain[SLOTS-1];
        if (commit) begin
            r_out_slot <= n_idx[OSLOT_W-1:0];
            r_out_sts  <= n_sts;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_slot   = r_out_slot;
    assign o_status = r_out_sts;

    // The search record leaves the chain only while the sequencer waits for it.
    `ASSERT_IMPLIES(a_tail_in_scan, i_clk, i_rst_n, w_chain[SLOTS-1].vld,
        r_state == ST_SCAN, "search record left chain outside scan")
    // A launch follows a lookup accept, so the sequencer is scanning.
    `ASSERT_IMPLIES(a_launch_in_scan, i_clk, i_rst_n, r_launch,
        r_state == ST_SCAN, "launch outside scan")
    // The access counter moves only on a commit.
    `ASSERT_NEXT(a_clock_hold, i_clk, i_rst_n, r_state != ST_FIN,
        $stable(r_clock), "access counter moved without commit")
    // A new result appears only out of the commit state.
    `ASSERT_IMPLIES(a_result_from_fin, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == ST_FIN, "result without commit")

endmodule

/* dv/tb_top.sv */
// Self-checking bench for the pinned LRU slot cache: directed and random requests,
// a live prediction of every reply and an in-order comparison on the result side.
// Depends on plsc_pkg and the pinned_lru_slot_cache RTL.
module tb_top;
    import plsc_pkg::*;

    localparam int NSLOT        = SLOTS_DEF;
    localparam int REF_TOP      = (1 << REF_BITS_DEF) - 1;
    localparam int POOL         = 48;           // more keys than slots, so evictions happen
    localparam int PHASE_ITEMS  = 250;
    localparam int DRAIN_CYCLES = 2 * (NSLOT + 3);
    localparam int LIMIT_CYCLES = 1_000_000;

    typedef struct {
        logic              func;
        logic [ADDR_W-1:0] addr;
        logic [NUM_W-1:0]  num;
        logic [REL_W-1:0]  rel;
    } req_t;

    typedef struct packed {
        logic [OSLOT_W-1:0] slot;
        logic [STS_W-1:0]   status;
    } reply_t;

    // Block inputs start at known values; reset is held low from time zero.
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               i_func         = FUNC_LOOKUP;
    logic [ADDR_W-1:0]  i_key_addr     = '0;
    logic [NUM_W-1:0]   i_key_num      = '0;
    logic [REL_W-1:0]   i_release_slot = '0;
    logic               i_stall        = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [OSLOT_W-1:0] o_slot;
    logic [STS_W-1:0]   o_status;

    pinned_lru_slot_cache #(
        .SLOTS    (NSLOT),
        .REF_BITS (REF_BITS_DEF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_key_addr     (i_key_addr),
        .i_key_num      (i_key_num),
        .i_release_slot (i_release_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_slot         (o_slot),
        .o_status       (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the cache: one line per slot plus the access counter
    // that stands in for the wall clock. Tags read as zero until written.
    // ------------------------------------------------------------------
    bit                    line_valid [NSLOT];
    bit [ADDR_W-1:0]       line_addr  [NSLOT];
    bit [NUM_W-1:0]        line_num   [NSLOT];
    bit [REF_BITS_DEF-1:0] line_refs  [NSLOT];
    bit [CLK_W-1:0]        line_stamp [NSLOT];
    bit [CLK_W-1:0]        use_clock;

    req_t   requests_todo[$];
    reply_t slot_replies_due[$];
    req_t   on_wire;

    int tx_idle_pct = 37;
    int rx_idle_pct = 48;
    int n_err, n_accepted, cycle_count;
    int n_hit, n_fill, n_evict, n_none, n_release;

    // Pin a line: bump its count (saturating), stamp it and advance the counter.
    function automatic void pin_line(int s);
        if (line_refs[s] != REF_BITS_DEF'(REF_TOP))
            line_refs[s] = line_refs[s] + 1'b1;
        line_stamp[s] = use_clock;
        use_clock     = use_clock + 1'b1;
    endfunction

    // Apply one request to the shadow cache and return the reply it must cause.
    function automatic reply_t cache_access(req_t rq);
        reply_t         rp;
        int             free_idx;
        int             victim;
        int             sel;
        bit [CLK_W-1:0] age;
        bit [CLK_W-1:0] best_age;
        free_idx = -1;
        victim   = -1;
        best_age = '0;
        if (rq.func == FUNC_RELEASE) begin
            // Release stops at zero, also on a line that was never filled.
            n_release++;
            if (line_refs[rq.rel] != 0)
                line_refs[rq.rel] = line_refs[rq.rel] - 1'b1;
            rp.slot   = rq.rel;
            rp.status = STS_HIT;
            return rp;
        end
        // A hit wins over any free line; the last free line seen is the highest one.
        for (int i = 0; i < NSLOT; i++) begin
            if (!line_valid[i]) begin
                free_idx = i;
            end else if (line_addr[i] == rq.addr && line_num[i] == rq.num) begin
                pin_line(i);
                n_hit++;
                rp.slot   = OSLOT_W'(i);
                rp.status = STS_HIT;
                return rp;
            end
        end
        if (free_idx < 0) begin
            // Oldest unpinned line goes; strict compare keeps the lowest index on a tie.
            for (int i = 0; i < NSLOT; i++) begin
                if (line_refs[i] == 0) begin
                    age = use_clock - line_stamp[i];
                    if (victim < 0 || age > best_age) begin
                        victim   = i;
                        best_age = age;
                    end
                end
            end
            if (victim < 0) begin
                // Every line pinned: nothing changes, the counter holds.
                n_none++;
                rp.slot   = '0;
                rp.status = STS_NONE;
                return rp;
            end
        end
        sel             = (free_idx >= 0) ? free_idx : victim;
        line_valid[sel] = 1'b1;
        line_addr[sel]  = rq.addr;
        line_num[sel]   = rq.num;
        line_refs[sel]  = '0;
        pin_line(sel);
        rp.slot   = OSLOT_W'(sel);
        rp.status = (free_idx >= 0) ? STS_FILL : STS_EVICT;
        if (free_idx >= 0)
            n_fill++;
        else
            n_evict++;
        return rp;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next pending item, hold it until accepted, and
    // predict its reply at the edge where the handshake completes.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (i_valid) begin
                slot_replies_due.push_back(cache_access(on_wire));
                n_accepted++;
            end
            if (requests_todo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                on_wire        = requests_todo.pop_front();
                i_valid        <= 1'b1;
                i_func         <= on_wire.func;
                i_key_addr     <= on_wire.addr;
                i_key_num      <= on_wire.num;
                i_release_slot <= on_wire.rel;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the result side at random, and check every accepted
    // reply against the oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        reply_t exp_rp;
        if (i_rst_n)
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (slot_replies_due.size() == 0) begin
                $display("%0t: reply with none expected: slot %0d status %0d",
                         $time, o_slot, o_status);
                n_err++;
            end else begin
                exp_rp = slot_replies_due.pop_front();
                if (o_slot !== exp_rp.slot || o_status !== exp_rp.status) begin
                    $display("%0t: reply mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                             $time, exp_rp.slot, exp_rp.status, o_slot, o_status);
                    n_err++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d replies outstanding", $time,
                     slot_replies_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Queue one item; hold off while the driver already has two waiting, so the
    // generator can react to the shadow state with little lag.
    task automatic queue_req(logic fn, logic [ADDR_W-1:0] a, logic [NUM_W-1:0] n,
                             logic [REL_W-1:0] r);
        req_t rq;
        while (requests_todo.size() >= 2)
            @(negedge i_clk);
        rq.func = fn;
        rq.addr = a;
        rq.num  = n;
        rq.rel  = r;
        requests_todo.push_back(rq);
    endtask

    // Wait until every item is accepted and every reply is back.
    task automatic wait_quiet();
        while (requests_todo.size() != 0 || i_valid || slot_replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: a directed opening, then three random phases that differ
    // in how often each side idles.
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit [ADDR_W-1:0] pool_addr [POOL];
        bit [NUM_W-1:0]  pool_num  [POOL];
        int              pinned[$];
        logic [ADDR_W-1:0] a;
        logic [NUM_W-1:0]  n;
        int made, burst, rel_pct, pick, k, lo, hi, rs;

        // Build the key pool; some keys share an address with the key before them or an
        // image number with the key two back, so that half-matching keys must miss.
        for (int p = 0; p < POOL; p++) begin
            pool_addr[p] = $urandom;
            pool_num[p]  = NUM_W'($urandom);
            if (p % 4 == 1)
                pool_addr[p] = pool_addr[p-1];
            if (p % 4 == 2)
                pool_num[p] = pool_num[p-2];
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Release a line that was never filled: count stays at zero.
        queue_req(FUNC_RELEASE, '1, '1, '0);
        // Fill the highest free lines with the extreme keys.
        queue_req(FUNC_LOOKUP, '0, '0, '1);
        queue_req(FUNC_LOOKUP, '1, '1, '0);
        // Hit beats the free lines still left.
        queue_req(FUNC_LOOKUP, '0, '0, '0);
        // Keys that match only in one half must place anew.
        queue_req(FUNC_LOOKUP, '0, '1, '1);
        queue_req(FUNC_LOOKUP, '1, '0, '0);
        // Unpin down to zero and once more past it.
        queue_req(FUNC_RELEASE, '0, '0, REL_W'(NSLOT - 1));
        queue_req(FUNC_RELEASE, '1, '1, REL_W'(NSLOT - 1));
        queue_req(FUNC_RELEASE, '0, '1, REL_W'(NSLOT - 1));
        // Hit on an unpinned line re-pins and restamps it.
        queue_req(FUNC_LOOKUP, '0, '0, '1);
        queue_req(FUNC_RELEASE, '1, '0, REL_W'(NSLOT - 2));

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 48;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 37;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            if (ph == 2) begin
                // Free up the least pinned line, then hammer one fresh key past
                // count saturation and back off a few releases.
                wait_quiet();
                lo = 0;
                for (int s = 1; s < NSLOT; s++)
                    if (line_refs[s] < line_refs[lo])
                        lo = s;
                repeat (int'(line_refs[lo]))
                    queue_req(FUNC_RELEASE, $urandom, NUM_W'($urandom), REL_W'(lo));
                a = $urandom;
                n = NUM_W'($urandom);
                repeat (REF_TOP + 3)
                    queue_req(FUNC_LOOKUP, a, n, REL_W'($urandom));
                wait_quiet();
                hi = 0;
                for (int s = 1; s < NSLOT; s++)
                    if (line_refs[s] > line_refs[hi])
                        hi = s;
                repeat (6)
                    queue_req(FUNC_RELEASE, $urandom, NUM_W'($urandom), REL_W'(hi));
            end

            made = 0;
            while (made < PHASE_ITEMS) begin
                // Each burst leans toward pinning, balance or unpinning, so the
                // cache swings between all-pinned, evicting and mostly free.
                burst = $urandom_range(60, 15);
                case ($urandom_range(2))
                    0:       rel_pct = 10;
                    1:       rel_pct = 45;
                    default: rel_pct = 75;
                endcase
                repeat (burst) begin
                    if ($urandom_range(99) < rel_pct) begin
                        // Mostly unpin a pinned line; now and then any line.
                        pinned.delete();
                        for (int s = 0; s < NSLOT; s++)
                            if (line_refs[s] != 0)
                                pinned.push_back(s);
                        if (pinned.size() != 0 && $urandom_range(99) < 85)
                            rs = pinned[$urandom_range(pinned.size() - 1)];
                        else
                            rs = $urandom_range(NSLOT - 1);
                        queue_req(FUNC_RELEASE, $urandom, NUM_W'($urandom), REL_W'(rs));
                    end else begin
                        // Pool keys for hits, near misses and wholly new keys.
                        pick = $urandom_range(99);
                        k    = $urandom_range(POOL - 1);
                        a    = pool_addr[k];
                        n    = pool_num[k];
                        if (pick >= 90) begin
                            a = $urandom;
                            n = NUM_W'($urandom);
                        end else if (pick >= 80) begin
                            if ($urandom_range(1))
                                a = a ^ (ADDR_W'(1) << $urandom_range(ADDR_W - 1));
                            else
                                n = n ^ (NUM_W'(1) << $urandom_range(NUM_W - 1));
                        end
                        queue_req(FUNC_LOOKUP, a, n, REL_W'($urandom));
                    end
                    made++;
                end
            end
        end

        // Let everything drain, then give a late spurious reply time to show.
        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d requests: %0d hits, %0d fills, %0d evictions, %0d refused, %0d releases.",
                 n_accepted, n_hit, n_fill, n_evict, n_none, n_release);
        $display("Idle mixes: sender-heavy, receiver-heavy, back to back; one line saturated its pin count.");
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/plsc_pkg.sv
src/plsc_cell.sv
src/pinned_lru_slot_cache.sv
dv/tb_top.sv
